/* rtl/nearest_color_lookup_defines.svh */
// Assertion macros used by the nearest color lookup search engine.
`ifndef NEAREST_COLOR_LOOKUP_DEFINES_SVH
`define NEAREST_COLOR_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ncl_pkg.sv */
// Types and constants shared by the nearest color lookup modules.
`timescale 1ns / 1ps
`default_nettype none

package ncl_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;
	localparam int COLOR_W     = 8;
	localparam int DIST_W      = 18;
	localparam int SQ_W        = 2 * COLOR_W;

	// Threshold 450, compared on the squared distance.
	localparam int DIST_LIMIT    = 450;
	localparam logic [DIST_W-1:0] DIST_LIMIT_SQ = DIST_W'(DIST_LIMIT * DIST_LIMIT);

	// Queue between the front and the engine; depth must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_e_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		cmd_e_t           kind;
		logic [IDX_W-1:0] entry_index;
		rgb_t             color;
	} item_t;

endpackage

`default_nettype wire

/* rtl/ncl_front.sv */
// Command front end: accepts and classifies commands and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none

module ncl_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          cmd,
	input  wire  [ncl_pkg::IDX_W-1:0]    entry_index,
	input  wire  [ncl_pkg::COLOR_W-1:0]  red,
	input  wire  [ncl_pkg::COLOR_W-1:0]  green,
	input  wire  [ncl_pkg::COLOR_W-1:0]  blue,
	output logic                         busy,
	output logic                         q_valid,
	output ncl_pkg::item_t               q_item,
	input  wire                          q_pop
);
	import ncl_pkg::*;

	item_t             fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             in_item;
	logic              push;
	logic              pop;

	always_comb begin
		in_item.entry_index = entry_index;
		in_item.color       = '{red: red, green: green, blue: blue};
		unique case (cmd)
			1'b1:    in_item.kind = CMD_QUERY;
			default: in_item.kind = CMD_WRITE;
		endcase
	end

	assign busy    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ncl_back.sv */
// Search engine: palette memory and the pipelined nearest-entry scan.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_color_lookup_defines.svh"

module ncl_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [ncl_pkg::CNT_W-1:0]    entry_count,
	input  wire                          q_valid,
	input  ncl_pkg::item_t               q_item,
	output logic                         q_pop,
	output logic                         result_valid,
	output logic [ncl_pkg::IDX_W-1:0]    nearest_index,
	output logic                         found,
	output logic [ncl_pkg::DIST_W-1:0]   distance_squared
);
	import ncl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	logic [3*COLOR_W-1:0] palette_mem [TABLE_DEPTH];

	rgb_t              query_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] last_addr_q;
	logic [DIST_W-1:0] best_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic              hit_q;

	logic                 valid_s1, last_s1;
	logic [ADDR_W-1:0]    idx_s1;
	logic [3*COLOR_W-1:0] rd_s1;

	logic              valid_s2, last_s2;
	logic [ADDR_W-1:0] idx_s2;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;

	logic              done_q;
	logic [IDX_W-1:0]  index_q;
	logic              found_q;
	logic [DIST_W-1:0] dist_q;

	logic [CNT_W-1:0]   limit;
	logic [CNT_W-1:0]   limit_m1;
	logic               issue;
	logic               mem_we;
	rgb_t               entry_s1;
	logic [COLOR_W-1:0] dr, dg, db;
	logic [DIST_W-1:0]  sum_s2;
	logic               better;
	logic [DIST_W-1:0]  new_best;
	logic [ADDR_W-1:0]  new_idx;
	logic               new_hit;

	// Counts above the table depth saturate.
	assign limit    = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;
	assign limit_m1 = limit - CNT_W'(1);

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign mem_we = q_pop && (q_item.kind == CMD_WRITE);
	assign issue  = (state_q == ST_SCAN);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			palette_mem[q_item.entry_index[ADDR_W-1:0]] <= q_item.color;
		end
		rd_s1 <= palette_mem[addr_q];
	end

	// Squared component distances.
	assign entry_s1 = rgb_t'(rd_s1);
	always_comb begin
		dr = (query_q.red   > entry_s1.red)   ? query_q.red   - entry_s1.red
		                                      : entry_s1.red   - query_q.red;
		dg = (query_q.green > entry_s1.green) ? query_q.green - entry_s1.green
		                                      : entry_s1.green - query_q.green;
		db = (query_q.blue  > entry_s1.blue)  ? query_q.blue  - entry_s1.blue
		                                      : entry_s1.blue  - query_q.blue;
	end

	always_ff @(posedge clk) begin
		idx_s1  <= addr_q;
		idx_s2  <= idx_s1;
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
	end

	// Strict compare keeps the first entry on a tie.
	always_comb begin
		sum_s2   = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
		better   = valid_s2 && (sum_s2 < best_q);
		new_best = better ? sum_s2 : best_q;
		new_idx  = better ? idx_s2 : best_idx_q;
		new_hit  = hit_q || better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			valid_s2    <= 1'b0;
			last_s2     <= 1'b0;
			done_q      <= 1'b0;
			index_q     <= '0;
			found_q     <= 1'b0;
			dist_q      <= '0;
			addr_q      <= '0;
			last_addr_q <= '0;
			best_q      <= DIST_LIMIT_SQ;
			best_idx_q  <= '0;
			hit_q       <= 1'b0;
			query_q     <= '0;
		end else begin
			valid_s1 <= issue;
			last_s1  <= issue && (addr_q == last_addr_q);
			valid_s2 <= valid_s1;
			last_s2  <= valid_s1 && last_s1;
			done_q   <= 1'b0;

			if (valid_s2) begin
				best_q     <= new_best;
				best_idx_q <= new_idx;
				hit_q      <= new_hit;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && (q_item.kind == CMD_QUERY)) begin
						query_q     <= q_item.color;
						addr_q      <= '0;
						last_addr_q <= limit_m1[ADDR_W-1:0];
						best_q      <= DIST_LIMIT_SQ;
						best_idx_q  <= '0;
						hit_q       <= 1'b0;
						if (limit == '0) begin
							done_q  <= 1'b1;
							index_q <= '0;
							found_q <= 1'b0;
							dist_q  <= '0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == last_addr_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s2 && last_s2) begin
						done_q  <= 1'b1;
						index_q <= new_hit ? IDX_W'(new_idx) : '0;
						found_q <= new_hit;
						dist_q  <= new_hit ? new_best : '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid     = done_q;
	assign nearest_index    = index_q;
	assign found            = found_q;
	assign distance_squared = dist_q;

	`NCL_ASSERT_NOW(a_found_under_limit, clk, arst_n, done_q && found_q, dist_q < DIST_LIMIT_SQ, "reported distance is not under the threshold")
	`NCL_ASSERT_NOW(a_miss_is_zero, clk, arst_n, done_q && !found_q, (dist_q == '0) && (index_q == '0), "miss result carries nonzero fields")
	`NCL_ASSERT_NEXT(a_issue_in_scan, clk, arst_n, issue, valid_s1 && (state_q == ST_SCAN || state_q == ST_DRAIN), "memory read issued outside a scan")
	`NCL_ASSERT_NEXT(a_done_returns_idle, clk, arst_n, state_q == ST_DRAIN && valid_s2 && last_s2, done_q && state_q == ST_IDLE, "scan end did not deliver a result")

endmodule

`default_nettype wire

/* rtl/nearest_color_lookup.sv */
// Top level of the nearest color lookup: palette search over RGB entries.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a palette of up to 1024 RGB colors and answers, for a query color, which
// entry in use is nearest by exact squared Euclidean distance, the first entry winning a tie.
// A command is transferred at a rising edge where start is high and busy is low; cmd low
// writes red, green and blue at entry_index (wrapped to the table depth), cmd high queries
// with red, green and blue and ignores entry_index. Commands pass through a two-deep queue
// into the search engine, so busy rises only when that queue is full. A write gives no
// result. A query scans entries 0 to entry_count minus one, one per cycle through the
// single read port of the palette memory (entry_count saturates at 1024); an empty table
// answers without a scan, with found low and zero fields. Each query gives one result,
// shown for exactly one cycle with result_valid high; the receiver cannot stall it and
// must take it in that cycle. The entry_count register must be written through cfg_we
// and cfg_data only while the block is idle; the block itself does not enforce this.
// Entries in use must have been written before a query reads them.
module nearest_color_lookup (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          cmd,
	input  wire  [ncl_pkg::IDX_W-1:0]    entry_index,
	input  wire  [ncl_pkg::COLOR_W-1:0]  red,
	input  wire  [ncl_pkg::COLOR_W-1:0]  green,
	input  wire  [ncl_pkg::COLOR_W-1:0]  blue,
	input  wire                          cfg_we,
	input  wire  [ncl_pkg::CNT_W-1:0]    cfg_data,
	output logic                         result_valid,
	output logic [ncl_pkg::IDX_W-1:0]    nearest_index,
	output logic                         found,
	output logic [ncl_pkg::DIST_W-1:0]   distance_squared
);
	import ncl_pkg::*;

	// Number of palette entries in use; the engine saturates it to the table depth.
	logic [CNT_W-1:0] entry_count_q;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_data;
		end
	end

	// The front end accepts each transfer and classifies it as a write or a query.
	ncl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.busy        (busy),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	// The engine owns the palette memory and runs one command at a time from the queue.
	ncl_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.entry_count      (entry_count_q),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.result_valid     (result_valid),
		.nearest_index    (nearest_index),
		.found            (found),
		.distance_squared (distance_squared)
	);

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the nearest color lookup palette search.
`timescale 1ns / 1ps

// The bench writes palette entries and queries through the start/busy command port.
// It keeps its own copy of the palette and of the entry count, and works out the
// nearest entry for every accepted query without a typed answer. Each answer goes
// into a queue in order. The result monitor checks every strobed result against the
// oldest queued answer. The run has two parts:
//   - a short table of directed steps, some with hand-typed answers;
//   - random phases over small entry counts, one of them with a few dozen
//     entries and one with an empty table.
// The entry count register is only changed once every answer has come back and
// the engine has had time to finish any trailing writes.
module tb_top;
	import ncl_pkg::*;

	// Cycles allowed after the last answer for queued writes to leave the engine.
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 62;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic              found;
		logic [DIST_W-1:0] distance;
	} nearest_t;

	typedef enum {ROW_WRITE, ROW_QUERY, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [IDX_W-1:0]  index;
		rgb_t              color;
		logic [CNT_W-1:0]  count;
		bit                typed;
		nearest_t          answer;
	} step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                cmd = 1'b0;
	logic [IDX_W-1:0]    entry_index = '0;
	logic [COLOR_W-1:0]  red = '0;
	logic [COLOR_W-1:0]  green = '0;
	logic [COLOR_W-1:0]  blue = '0;
	logic                cfg_we = 1'b0;
	logic [CNT_W-1:0]    cfg_data = '0;
	logic                result_valid;
	logic [IDX_W-1:0]    nearest_index;
	logic                found;
	logic [DIST_W-1:0]   distance_squared;

	// Bench copy of the block state.
	rgb_t                palette_copy [TABLE_DEPTH];
	bit                  written [TABLE_DEPTH];
	logic [CNT_W-1:0]    count_copy = '0;

	// Answers still owed by the block, oldest first.
	nearest_t            pending_answers [$];

	bit                  burst_mode = 1'b0;
	int                  error_count = 0;
	int                  n_writes = 0;
	int                  n_queries = 0;
	int                  n_checked = 0;
	int                  n_settings = 0;

	step_t               directed [19];

	nearest_color_lookup u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.entry_index      (entry_index),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.nearest_index    (nearest_index),
		.found            (found),
		.distance_squared (distance_squared)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Scan the entries in use in ascending order. A later entry replaces the
	// current best only when it is strictly closer, so the first one wins a tie.
	// The starting bound is the squared threshold, which every RGB distance lies
	// under. As a result, found is low only for an empty table.
	function automatic nearest_t find_nearest(rgb_t q);
		nearest_t    res;
		int unsigned used;
		int unsigned best;
		int unsigned d;
		int          dr;
		int          dg;
		int          db;
		res  = '0;
		best = DIST_LIMIT * DIST_LIMIT;
		used = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy;
		for (int unsigned i = 0; i < used; i++) begin
			dr = int'(q.red) - int'(palette_copy[i].red);
			dg = int'(q.green) - int'(palette_copy[i].green);
			db = int'(q.blue) - int'(palette_copy[i].blue);
			d  = dr * dr + dg * dg + db * db;
			if (d < best) begin
				best         = d;
				res.index    = IDX_W'(i);
				res.found    = 1'b1;
				res.distance = DIST_W'(d);
			end
		end
		return res;
	endfunction

	// Each channel is mostly random, with the extremes drawn now and then.
	function automatic rgb_t random_color();
		rgb_t c;
		logic [COLOR_W-1:0] ch [3];
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 7))
				0: ch[k] = '0;
				1: ch[k] = '1;
				default: ch[k] = COLOR_W'($urandom_range(0, 255));
			endcase
		end
		c.red   = ch[0];
		c.green = ch[1];
		c.blue  = ch[2];
		return c;
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		error_count++;
		if (error_count <= 50)
			$display("tb_top: mismatch at %0t ns on %s: expected %0d, got %0d",
				$time, what, want, got);
	endtask

	// Drives one command and holds it until the block takes it. The bench mirror
	// is updated at the transfer edge. Then comes the drawn idle gap, with start
	// low. Every call starts and ends on a rising edge, and start is assigned at
	// most once per edge.
	task automatic issue(cmd_e_t kind, logic [IDX_W-1:0] index, rgb_t color,
			bit typed, nearest_t typed_answer);
		int gap;
		start       <= 1'b1;
		cmd         <= kind;
		entry_index <= index;
		red         <= color.red;
		green       <= color.green;
		blue        <= color.blue;
		do
			@(posedge clk);
		while (busy);
		if (kind == CMD_WRITE) begin
			palette_copy[index] = color;
			written[index]      = 1'b1;
			n_writes++;
		end else begin
			pending_answers.push_back(typed ? typed_answer : find_nearest(color));
			n_queries++;
		end
		gap = burst_mode ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending until every owed answer has arrived, then let any trailing
	// writes leave the command queue and the engine.
	task automatic wait_results_done();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The entry count register is changed only while the block is idle.
	task automatic set_count(logic [CNT_W-1:0] value);
		wait_results_done();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		count_copy = value;
		n_settings++;
	endtask

	// A result is on the ports for one cycle only. It is taken at the edge that
	// ends that cycle, so this block reads the values from before the edge.
	always @(posedge clk) begin
		nearest_t want;
		if (arst_n && result_valid) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result", 0, 1);
			end else begin
				want = pending_answers.pop_front();
				n_checked++;
				if (nearest_index !== want.index)
					report_mismatch("nearest_index", want.index, nearest_index);
				if (found !== want.found)
					report_mismatch("found", want.found, found);
				if (distance_squared !== want.distance)
					report_mismatch("distance_squared", want.distance, distance_squared);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		nearest_t             none;
		rgb_t                 c;
		logic [IDX_W-1:0]     idx;
		int                   used;
		int                   pick;
		none = '0;
		foreach (palette_copy[i]) begin
			palette_copy[i] = '0;
			written[i]      = 1'b0;
		end

		// Directed steps. Typed answers cover these cases:
		//   - an empty table, including the empty table after a count of zero;
		//   - exact hits, one of them a tie that the lower index must win;
		//   - the largest possible distance.
		// Other rows go through the predictor.
		directed = '{
			'{ROW_QUERY,  10'd1023, 24'h0C2238, 11'd0, 1'b1, {10'd0, 1'b0, 18'd0}},
			'{ROW_WRITE,  10'd0,    24'h000000, 11'd0, 1'b0, 29'd0},
			'{ROW_WRITE,  10'd1,    24'hFFFFFF, 11'd0, 1'b0, 29'd0},
			'{ROW_WRITE,  10'd2,    24'hFF0000, 11'd0, 1'b0, 29'd0},
			'{ROW_WRITE,  10'd3,    24'h000000, 11'd0, 1'b0, 29'd0},
			'{ROW_WRITE,  10'd1023, 24'h00FF00, 11'd0, 1'b0, 29'd0},
			'{ROW_CONFIG, 10'd0,    24'h000000, 11'd4, 1'b0, 29'd0},
			'{ROW_QUERY,  10'd0,    24'h000000, 11'd0, 1'b1, {10'd0, 1'b1, 18'd0}},
			'{ROW_QUERY,  10'd3,    24'hFFFFFF, 11'd0, 1'b1, {10'd1, 1'b1, 18'd0}},
			'{ROW_QUERY,  10'd0,    24'hFFFF00, 11'd0, 1'b0, 29'd0},
			'{ROW_QUERY,  10'd555,  24'h808080, 11'd0, 1'b0, 29'd0},
			'{ROW_CONFIG, 10'd0,    24'h000000, 11'd0, 1'b0, 29'd0},
			'{ROW_QUERY,  10'd0,    24'hFFFFFF, 11'd0, 1'b1, {10'd0, 1'b0, 18'd0}},
			'{ROW_CONFIG, 10'd0,    24'h000000, 11'd1, 1'b0, 29'd0},
			'{ROW_QUERY,  10'd0,    24'hFFFFFF, 11'd0, 1'b1, {10'd0, 1'b1, 18'd195075}},
			'{ROW_WRITE,  10'd0,    24'hFFFFFF, 11'd0, 1'b0, 29'd0},
			'{ROW_QUERY,  10'd0,    24'h000000, 11'd0, 1'b1, {10'd0, 1'b1, 18'd195075}},
			'{ROW_CONFIG, 10'd0,    24'h000000, 11'd4, 1'b0, 29'd0},
			'{ROW_QUERY,  10'd682,  24'h0000FF, 11'd0, 1'b0, 29'd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_CONFIG: set_count(directed[i].count);
				ROW_WRITE: issue(CMD_WRITE, directed[i].index, directed[i].color, 1'b0, none);
				default: issue(CMD_QUERY, directed[i].index, directed[i].color,
					directed[i].typed, directed[i].answer);
			endcase
		end

		// Random phases. Every entry that is about to come into use is written
		// first, because reading an unwritten entry is outside the contract. Most
		// phases use small counts to keep the scans short. One phase uses a few
		// dozen entries, and one phase uses an empty table.
		for (int ph = 0; ph < PHASES; ph++) begin
			burst_mode = ($urandom_range(0, 2) == 0);
			if (ph == 2)
				used = 0;
			else if (ph == 5)
				used = $urandom_range(40, 64);
			else
				used = $urandom_range(1, 24);
			for (int i = 0; i < used; i++)
				if (!written[i])
					issue(CMD_WRITE, IDX_W'(i), random_color(), 1'b0, none);
			set_count(CNT_W'(used));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				idx  = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
				if (pick < 40) begin
					// Writes mostly land inside the table in use, so that later
					// queries see the changed colors.
					if (used > 0 && pick < 25)
						idx = IDX_W'($urandom_range(0, used - 1));
					issue(CMD_WRITE, idx, random_color(), 1'b0, none);
				end else begin
					// A copy of a stored color gives an exact hit, and often a tie.
					if (used > 0 && pick < 60)
						c = palette_copy[$urandom_range(0, used - 1)];
					else
						c = random_color();
					issue(CMD_QUERY, idx, c, 1'b0, none);
				end
				if ($urandom_range(0, 24) == 0)
					wait_results_done();
			end
		end

		wait_results_done();
		repeat (20) @(posedge clk);

		$display("tb_top: %0d palette writes and %0d queries sent, %0d results checked",
			n_writes, n_queries, n_checked);
		$display("tb_top: %0d entry count settings, from an empty table to a few dozen entries",
			n_settings);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
